// File: src/lkrc_pkg.sv
// ----------------------------------------------------------------------------
// lkrc_pkg
// Shared types and constants of the keyed result cache: the key, the command
// broadcast along the row of cells, the request codes.
// ----------------------------------------------------------------------------
package lkrc_pkg;

	localparam int DEF_ENTRIES = 16;

	localparam logic [4:0]  CAP_RESET = 5'd16;
	localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

	localparam logic [1:0] MODE_FIND   = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_INVAL  = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	typedef struct packed {
		logic [63:0] content;
		logic [15:0] face;
		logic [15:0] size;
		logic [6:0]  level;
		logic [7:0]  script;
		logic [31:0] language;
	} key_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOOK,
		OP_APPLY,
		OP_CLEAR,
		OP_INVAL
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		key_t        key;
		logic [31:0] value;
		logic        touch_en;
		logic        write_key;
		logic        write_data;
		logic        all_inc;
		logic        hit_any;
		logic        evict;
		logic        drop;
	} cell_cmd_t;

	typedef struct packed {
		logic        hit;
		logic        inval_hit;
		logic [31:0] data;
	} cell_stat_t;

endpackage

// File: src/lru_keyed_result_cache.sv
// ----------------------------------------------------------------------------
// lru_keyed_result_cache
// Fully associative keyed cache with exact LRU replacement, built as a row of
// slot cells that compare in parallel and keep recency as packed ranks.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Carries
// in        input      in_valid / in_ready    mode, key fields, entry_value
// out       output     out_valid / out_ready  found, value, evicted, count, stats
// cfg       input      cfg_valid / cfg_ready  capacity_in_use (cfg_data)
//
// Find and insert: the accept cycle compares the key in every cell, then the
// apply state updates ranks, writes the slot and loads the result.
// Invalidate takes one step per rank, top rank down, then the final state.
// Clear empties every cell in the final state. One item is in work at a time;
// the result register lets the next item in while the last result waits.
// Reset clears all valid bits and counters and sets the capacity to 16 at
// once; no sweep.
// A stalled output holds the final cycle of the item in work.
//
module lru_keyed_result_cache import lkrc_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] content_hash,
	input  logic [15:0] face_index,
	input  logic [15:0] size_in_sixteenths,
	input  logic [6:0]  bidi_level,
	input  logic [7:0]  script_code,
	input  logic [31:0] language_code,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] found_value,
	output logic        evicted,
	output logic [4:0]  entries_held,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count,
	output logic [31:0] eviction_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_INVAL,
		ST_FIN
	} state_t;

	state_t        state_q;
	key_t          req_q;
	logic [31:0]   value_q;
	logic [1:0]    mode_q;
	logic          hit_q;
	logic          evict_q;
	logic [RW-1:0] pivot_q;
	logic [RW-1:0] step_q;
	logic [31:0]   fval_q;
	logic [CW-1:0] count_q;
	logic [4:0]    cap_q;
	logic [31:0]   hits_q;
	logic [31:0]   misses_q;
	logic [31:0]   evicts_q;

	key_t          in_key;
	cell_cmd_t     cmd;
	logic [RW-1:0] pivot;
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] inval_vec;
	logic [ENTRIES:0]   free_c;
	cell_stat_t    stat [ENTRIES];
	logic [RW-1:0] rank_g [ENTRIES];
	logic [RW-1:0] hit_rank;
	logic [31:0]   hit_data;
	logic          hit_any;
	logic          drop;
	logic [CMPW-1:0] cap_eff;
	logic          full;
	logic [RW-1:0] count_m1;
	logic          out_free;
	logic          load_out;
	logic          fill;
	logic [CW-1:0] count_fill;

	assign in_key.content  = content_hash;
	assign in_key.face     = face_index;
	assign in_key.size     = size_in_sixteenths;
	assign in_key.level    = bidi_level;
	assign in_key.script   = script_code;
	assign in_key.language = language_code;

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	// the final cycle of an item loads the result register
	assign load_out  = ((state_q == ST_APPLY) || (state_q == ST_FIN)) && out_free;

	// clamp capacity to 1..ENTRIES
	always_comb begin
		if (cap_q == 5'd0) begin
			cap_eff = CMPW'(1);
		end else if (CMPW'(cap_q) > CMPW'(ENTRIES)) begin
			cap_eff = CMPW'(ENTRIES);
		end else begin
			cap_eff = CMPW'(cap_q);
		end
	end

	assign full     = CMPW'(count_q) >= cap_eff;
	assign count_m1 = RW'(count_q - CW'(1));
	assign fill     = (mode_q == MODE_INSERT) && !hit_q && !evict_q;
	assign count_fill = count_q + CW'(fill);

	// gather the cell outputs; at most one cell hits
	always_comb begin
		hit_rank = '0;
		hit_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i]   = stat[i].hit;
			inval_vec[i] = stat[i].inval_hit;
			hit_rank     = hit_rank | rank_g[i];
			hit_data     = hit_data | stat[i].data;
		end
	end

	assign hit_any = |hit_vec;
	assign drop    = |inval_vec;

	always_comb begin
		case (state_q)
			ST_IDLE:  pivot = count_m1;
			ST_INVAL: pivot = step_q;
			default:  pivot = pivot_q;
		endcase
	end

	always_comb begin
		cmd.key        = (state_q == ST_IDLE) ? in_key : req_q;
		cmd.value      = value_q;
		cmd.touch_en   = ((mode_q == MODE_FIND) && hit_q) || (mode_q == MODE_INSERT);
		cmd.write_key  = (mode_q == MODE_INSERT) && !hit_q;
		cmd.write_data = mode_q == MODE_INSERT;
		cmd.all_inc    = fill;
		cmd.hit_any    = hit_any;
		cmd.evict      = !hit_any && full;
		cmd.drop       = drop;
		case (state_q)
			ST_IDLE:  cmd.op = OP_LOOK;
			ST_APPLY: cmd.op = out_free ? OP_APPLY : OP_HOLD;
			ST_INVAL: cmd.op = OP_INVAL;
			ST_FIN:   cmd.op = (out_free && mode_q == MODE_CLEAR) ? OP_CLEAR : OP_HOLD;
			default:  cmd.op = OP_HOLD;
		endcase
	end

	assign free_c[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkrc_cell #(
			.RW (RW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.pivot    (pivot),
			.free_in  (free_c[g]),
			.free_out (free_c[g+1]),
			.stat     (stat[g]),
			.hit_rank (rank_g[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			cap_q          <= CAP_RESET;
			hits_q         <= '0;
			misses_q       <= '0;
			evicts_q       <= '0;
			out_valid      <= 1'b0;
			found          <= 1'b0;
			found_value    <= '0;
			evicted        <= 1'b0;
			entries_held   <= '0;
			hit_count      <= '0;
			miss_count     <= '0;
			eviction_count <= '0;
			req_q          <= '0;
			value_q        <= '0;
			mode_q         <= MODE_FIND;
			hit_q          <= 1'b0;
			evict_q        <= 1'b0;
			pivot_q        <= '0;
			step_q         <= '0;
			fval_q         <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						req_q   <= in_key;
						value_q <= entry_value;
						hit_q   <= hit_any;
						evict_q <= !hit_any && full;
						pivot_q <= hit_any ? hit_rank : count_m1;
						fval_q  <= hit_data;
						step_q  <= RW'(ENTRIES - 1);
						case (mode)
							MODE_FIND:   state_q <= ST_APPLY;
							MODE_INSERT: state_q <= ST_APPLY;
							MODE_INVAL:  state_q <= ST_INVAL;
							default:     state_q <= ST_FIN;
						endcase
					end
				end
				ST_APPLY: begin
					// hold until the result register is free
					if (out_free) begin
						count_q <= count_fill;
						if (mode_q == MODE_FIND) begin
							if (hit_q) begin
								hits_q    <= (hits_q == CNT_MAX) ? hits_q : hits_q + 32'd1;
								hit_count <= (hits_q == CNT_MAX) ? hits_q : hits_q + 32'd1;
							end else begin
								misses_q   <= (misses_q == CNT_MAX) ? misses_q : misses_q + 32'd1;
								miss_count <= (misses_q == CNT_MAX) ? misses_q : misses_q + 32'd1;
							end
						end
						if (mode_q == MODE_INSERT && !hit_q && evict_q) begin
							evicts_q       <= (evicts_q == CNT_MAX) ? evicts_q : evicts_q + 32'd1;
							eviction_count <= (evicts_q == CNT_MAX) ? evicts_q : evicts_q + 32'd1;
						end
						found        <= (mode_q == MODE_FIND) && hit_q;
						found_value  <= ((mode_q == MODE_FIND) && hit_q) ? fval_q : 32'd0;
						evicted      <= (mode_q == MODE_INSERT) && !hit_q && evict_q;
						entries_held <= 5'(count_fill);
						state_q      <= ST_IDLE;
					end
				end
				ST_INVAL: begin
					count_q <= count_q - CW'(drop);
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q - RW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (mode_q == MODE_CLEAR) begin
							count_q <= '0;
						end
						found          <= 1'b0;
						found_value    <= 32'd0;
						evicted        <= 1'b0;
						entries_held   <= (mode_q == MODE_CLEAR) ? 5'd0 : 5'(count_q);
						hit_count      <= hits_q;
						miss_count     <= misses_q;
						eviction_count <= evicts_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_APPLY && out_free) begin
				if (!(mode_q == MODE_FIND && hit_q)) begin
					hit_count <= hits_q;
				end
				if (!(mode_q == MODE_FIND && !hit_q)) begin
					miss_count <= misses_q;
				end
				if (!(mode_q == MODE_INSERT && !hit_q && evict_q)) begin
					eviction_count <= evicts_q;
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(ENTRIES))
		else $error("held count beyond store size");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key held in more than one slot");

	a_hit_not_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && evicted))
		else $error("result both hit and evicted");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && mode_q == MODE_CLEAR && out_free) |=> count_q == '0)
		else $error("clear left entries held");

	a_fill_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && mode == MODE_INSERT && !hit_any && !full)
		|-> free_c[ENTRIES])
		else $error("fill with no free slot");

endmodule

// File: src/lkrc_cell.sv
// ----------------------------------------------------------------------------
// lkrc_cell
// One cache slot: key, value, valid bit and recency rank. Compares its key
// against the broadcast key and updates its rank from the broadcast command.
// ----------------------------------------------------------------------------
module lkrc_cell import lkrc_pkg::*; #(
	parameter int RW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_cmd_t     cmd,
	input  logic [RW-1:0] pivot,
	input  logic          free_in,
	output logic          free_out,
	output cell_stat_t    stat,
	output logic [RW-1:0] hit_rank
);

	key_t          key_q;
	logic [31:0]   data_q;
	logic [RW-1:0] rank_q;
	logic          valid_q;
	logic          sel_q;

	logic hit;
	logic lang_eq;

	assign hit      = valid_q && (key_q == cmd.key);
	assign lang_eq  = key_q.language == cmd.key.language;
	assign free_out = free_in || !valid_q;

	assign stat.hit       = hit;
	assign stat.inval_hit = valid_q && lang_eq && (rank_q == pivot);
	assign stat.data      = hit ? data_q : 32'd0;
	assign hit_rank       = hit ? rank_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOOK: begin
					// pick the target slot: the hit, else the LRU victim, else first free
					if (cmd.hit_any) begin
						sel_q <= hit;
					end else if (cmd.evict) begin
						sel_q <= valid_q && (rank_q == pivot);
					end else begin
						sel_q <= !valid_q && !free_in;
					end
				end
				OP_APPLY: begin
					if (cmd.touch_en) begin
						if (sel_q) begin
							rank_q  <= '0;
							valid_q <= 1'b1;
							if (cmd.write_key) begin
								key_q <= cmd.key;
							end
							if (cmd.write_data) begin
								data_q <= cmd.value;
							end
						end else if (valid_q && (cmd.all_inc || rank_q < pivot)) begin
							rank_q <= rank_q + RW'(1);
						end
					end
				end
				OP_INVAL: begin
					// drop at this rank, close the gap above it
					if (stat.inval_hit) begin
						valid_q <= 1'b0;
					end else if (valid_q && cmd.drop && rank_q > pivot) begin
						rank_q <= rank_q - RW'(1);
					end
				end
				OP_CLEAR: begin
					valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: tb/lru_keyed_result_cache_test.sv
// ----------------------------------------------------------------------------
// lru_keyed_result_cache_test
// Self-checking bench for the keyed LRU result cache. A behavioral copy of
// the cache predicts every result, and a checker compares each result as it
// leaves. The bench runs directed cases first, then random traffic over a
// small key pool under several capacity settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module lru_keyed_result_cache_test;
	import lkrc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = DEF_ENTRIES;
	localparam int CYCLE_CAP  = 600000;
	localparam int POOL_SIZE  = 24;

	typedef struct {
		logic [1:0]  mode;
		key_t        key;
		logic [31:0] value;
	} request_t;

	typedef struct {
		logic        found;
		logic [31:0] found_value;
		logic        evicted;
		logic [4:0]  entries_held;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] eviction_count;
	} lookup_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_FIND;
	logic [63:0] content_hash = '0;
	logic [15:0] face_index = '0;
	logic [15:0] size_in_sixteenths = '0;
	logic [6:0]  bidi_level = '0;
	logic [7:0]  script_code = '0;
	logic [31:0] language_code = '0;
	logic [31:0] entry_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [31:0] found_value;
	logic        evicted;
	logic [4:0]  entries_held;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] eviction_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;

	lru_keyed_result_cache dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .content_hash(content_hash), .face_index(face_index),
		.size_in_sixteenths(size_in_sixteenths), .bidi_level(bidi_level),
		.script_code(script_code), .language_code(language_code),
		.entry_value(entry_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .found_value(found_value), .evicted(evicted),
		.entries_held(entries_held), .hit_count(hit_count),
		.miss_count(miss_count), .eviction_count(eviction_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Behavioral copy of the cache state.
	logic [4:0]  cap_reg;
	logic        held_valid [SLOTS];
	key_t        held_key   [SLOTS];
	logic [31:0] held_data  [SLOTS];
	int unsigned held_rank  [SLOTS];
	logic [31:0] hits_seen, misses_seen, evictions_seen;

	lookup_result_t pending_results[$];
	int             error_count = 0;
	int             results_checked = 0;
	int             items_sent = 0;
	int unsigned    cycle_count = 0;
	int             burst_left = 0;
	key_t           key_pool [POOL_SIZE];
	logic [31:0]    language_pool [4];

	function automatic logic [31:0] bump(logic [31:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

	function automatic int count_held();
		int n = 0;
		for (int i = 0; i < SLOTS; i++) if (held_valid[i]) n++;
		return n;
	endfunction

	// Make slot s the most recent; younger entries age by one.
	function automatic void make_recent(int s);
		int unsigned r = held_rank[s];
		for (int i = 0; i < SLOTS; i++)
			if (held_valid[i] && i != s && held_rank[i] < r) held_rank[i]++;
		held_rank[s] = 0;
	endfunction

	function automatic void pack_ranks();
		int unsigned nr [SLOTS];
		for (int i = 0; i < SLOTS; i++) begin
			nr[i] = 0;
			if (held_valid[i])
				for (int j = 0; j < SLOTS; j++)
					if (held_valid[j] && held_rank[j] < held_rank[i]) nr[i]++;
		end
		for (int i = 0; i < SLOTS; i++) if (held_valid[i]) held_rank[i] = nr[i];
	endfunction

	function automatic lookup_result_t cache_lookup(request_t rq);
		lookup_result_t res;
		int cap, hit_slot, s;
		int unsigned worst;
		res = '{default: '0};
		cap = cap_reg;
		if (cap == 0) cap = 1;
		if (cap > SLOTS) cap = SLOTS;
		hit_slot = -1;
		if (rq.mode == MODE_FIND || rq.mode == MODE_INSERT)
			for (int i = 0; i < SLOTS; i++)
				if (hit_slot < 0 && held_valid[i] && held_key[i] == rq.key) hit_slot = i;
		case (rq.mode)
			MODE_FIND: begin
				if (hit_slot >= 0) begin
					make_recent(hit_slot);
					res.found = 1'b1;
					res.found_value = held_data[hit_slot];
					hits_seen = bump(hits_seen);
				end else begin
					misses_seen = bump(misses_seen);
				end
			end
			MODE_INSERT: begin
				if (hit_slot >= 0) begin
					held_data[hit_slot] = rq.value;
					make_recent(hit_slot);
				end else begin
					s = -1;
					worst = 0;
					if (count_held() >= cap) begin
						// evict the least recent entry, first slot on ties
						for (int i = 0; i < SLOTS; i++)
							if (held_valid[i] && (s < 0 || held_rank[i] > worst)) begin
								s = i;
								worst = held_rank[i];
							end
						res.evicted = 1'b1;
						evictions_seen = bump(evictions_seen);
						make_recent(s);
					end else begin
						for (int i = 0; i < SLOTS; i++)
							if (s < 0 && !held_valid[i]) s = i;
						for (int i = 0; i < SLOTS; i++) if (held_valid[i]) held_rank[i]++;
					end
					held_valid[s] = 1'b1;
					held_key[s] = rq.key;
					held_data[s] = rq.value;
					held_rank[s] = 0;
				end
			end
			MODE_INVAL: begin
				for (int i = 0; i < SLOTS; i++)
					if (held_valid[i] && held_key[i].language == rq.key.language)
						held_valid[i] = 1'b0;
				pack_ranks();
			end
			default: begin
				for (int i = 0; i < SLOTS; i++) held_valid[i] = 1'b0;
			end
		endcase
		res.entries_held = 5'(count_held());
		res.hit_count = hits_seen;
		res.miss_count = misses_seen;
		res.eviction_count = evictions_seen;
		return res;
	endfunction

	// Receiver: pick a stall style - always ready, coin flip, or long stalls.
	int unsigned ready_style = 0;
	always @(posedge clk) begin
		if (cycle_count % 48 == 0) ready_style <= $urandom_range(0, 2);
		case (ready_style)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Checker: compare every accepted result against the oldest prediction.
	always @(posedge clk) begin
		lookup_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no prediction waiting");
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				if (found !== exp_r.found) begin
					$error("found: expected %0d, got %0d", exp_r.found, found);
					error_count++;
				end
				if (found_value !== exp_r.found_value) begin
					$error("found_value: expected %0h, got %0h", exp_r.found_value, found_value);
					error_count++;
				end
				if (evicted !== exp_r.evicted) begin
					$error("evicted: expected %0d, got %0d", exp_r.evicted, evicted);
					error_count++;
				end
				if (entries_held !== exp_r.entries_held) begin
					$error("entries_held: expected %0d, got %0d",
						exp_r.entries_held, entries_held);
					error_count++;
				end
				if (hit_count !== exp_r.hit_count) begin
					$error("hit_count: expected %0d, got %0d", exp_r.hit_count, hit_count);
					error_count++;
				end
				if (miss_count !== exp_r.miss_count) begin
					$error("miss_count: expected %0d, got %0d", exp_r.miss_count, miss_count);
					error_count++;
				end
				if (eviction_count !== exp_r.eviction_count) begin
					$error("eviction_count: expected %0d, got %0d",
						exp_r.eviction_count, eviction_count);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, pending_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Send one item; hold valid and payload until accepted, then predict.
	// Valid stays high into the next item unless a gap is due.
	task automatic send_item(request_t rq);
		lookup_result_t predicted;
		mode <= rq.mode;
		content_hash <= rq.key.content;
		face_index <= rq.key.face;
		size_in_sixteenths <= rq.key.size;
		bidi_level <= rq.key.level;
		script_code <= rq.key.script;
		language_code <= rq.key.language;
		entry_value <= rq.value;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = cache_lookup(rq);
		pending_results = {pending_results, predicted};
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [4:0] cap);
		drain();
		cfg_data <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = cap;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic request_t make_req(logic [1:0] m, key_t k, logic [31:0] v);
		request_t rq;
		rq.mode = m;
		rq.key = k;
		rq.value = v;
		return rq;
	endfunction

	function automatic key_t rand_key();
		key_t k;
		k.content = {$urandom, $urandom};
		k.face = 16'($urandom);
		k.size = 16'($urandom);
		k.level = 7'($urandom_range(0, 125));
		k.script = 8'($urandom);
		k.language = $urandom;
		return k;
	endfunction

	// Extremes of every key field, find miss then insert then hit, update.
	task automatic test_key_extremes();
		key_t lo, hi;
		lo = '{default: '0};
		hi = '{content: '1, face: '1, size: '1, level: 7'd125, script: '1, language: '1};
		send_item(make_req(MODE_FIND, lo, 32'h0));
		send_item(make_req(MODE_INSERT, lo, 32'hFFFF_FFFF));
		send_item(make_req(MODE_INSERT, hi, 32'h0));
		send_item(make_req(MODE_FIND, lo, 32'h0));
		send_item(make_req(MODE_FIND, hi, 32'h0));
		send_item(make_req(MODE_INSERT, hi, 32'hA5A5_5A5A));
		send_item(make_req(MODE_FIND, hi, 32'h0));
		drain();
	endtask

	// Fill past capacity to force eviction of the least recent entry,
	// then invalidate one language and clear everything.
	task automatic test_eviction_and_drop();
		key_t k;
		for (int i = 0; i < SLOTS + 2; i++) begin
			k = key_pool[i % POOL_SIZE];
			send_item(make_req(MODE_INSERT, k, $urandom));
		end
		send_item(make_req(MODE_FIND, key_pool[3], 32'h0));
		send_item(make_req(MODE_INVAL, key_pool[2], 32'h0));
		send_item(make_req(MODE_FIND, key_pool[2], 32'h0));
		send_item(make_req(MODE_CLEAR, key_pool[0], 32'h0));
		drain();
	endtask

	// Zero capacity acts as one; a capacity above the store acts as full;
	// lowering the capacity below the held count drops nothing.
	task automatic test_capacity_corners();
		set_capacity(5'd0);
		send_item(make_req(MODE_INSERT, key_pool[0], 32'h11));
		send_item(make_req(MODE_INSERT, key_pool[1], 32'h22));
		set_capacity(5'd31);
		for (int i = 2; i < 8; i++) send_item(make_req(MODE_INSERT, key_pool[i], $urandom));
		set_capacity(5'd2);
		send_item(make_req(MODE_INSERT, key_pool[9], 32'h33));
		send_item(make_req(MODE_FIND, key_pool[4], 32'h0));
		send_item(make_req(MODE_CLEAR, key_pool[0], 32'h0));
		set_capacity(CAP_RESET);
	endtask

	// Random traffic, mostly finds and inserts over the key pool.
	task automatic test_random_traffic(int count);
		request_t rq;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			rq.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			rq.value = $urandom;
			if (pick < 45) rq.mode = MODE_FIND;
			else if (pick < 87) rq.mode = MODE_INSERT;
			else if (pick < 94) rq.mode = MODE_INVAL;
			else if (pick < 96) rq.mode = MODE_CLEAR;
			else begin
				rq.mode = 2'($urandom_range(0, 1));
				rq.key = rand_key();
			end
			send_item(rq);
		end
	endtask

	initial begin
		logic [4:0] caps [6];
		caps = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd12};
		cap_reg = CAP_RESET;
		hits_seen = '0;
		misses_seen = '0;
		evictions_seen = '0;
		for (int i = 0; i < SLOTS; i++) begin
			held_valid[i] = 1'b0;
			held_key[i] = '0;
			held_data[i] = '0;
			held_rank[i] = 0;
		end
		for (int i = 0; i < 4; i++) language_pool[i] = $urandom;
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = rand_key();
			key_pool[i].language = language_pool[i % 4];
		end
		// Near-twin keys: 21 and 22 differ from key 0 in one field only; 20 takes key 0's content with the top bit flipped.
		key_pool[20].content = key_pool[0].content ^ 64'h8000_0000_0000_0000;
		key_pool[21] = key_pool[0];
		key_pool[21].level = key_pool[0].level ^ 7'h01;
		key_pool[22] = key_pool[0];
		key_pool[22].script = ~key_pool[0].script;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_key_extremes();
		test_eviction_and_drop();
		test_capacity_corners();
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			test_random_traffic(210);
		end
		drain();

		$display("covered %0d items and %0d results over capacities 0..31,",
			items_sent, results_checked);
		$display("with hits, misses, updates, evictions, invalidations and clears");
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", error_count);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: lru_keyed_result_cache.f
src/lkrc_pkg.sv
src/lkrc_cell.sv
src/lru_keyed_result_cache.sv
tb/lru_keyed_result_cache_test.sv
